### hw/rtl/mips_subset_skip_executor_defines.svh
// Assertion macros for the MIPS subset skip executor.
// Used by the top level; expects clk and rst in scope where expanded.
`ifndef MIPS_SUBSET_SKIP_EXECUTOR_DEFINES_SVH
`define MIPS_SUBSET_SKIP_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mss_pkg.sv
// Shared types and constants for the MIPS subset skip executor.
// No dependencies; used by mss_exec and the top level.
package mss_pkg;

  // Default data memory depth in words
  localparam int MEM_WORDS_DEFAULT = 32;

  // Command codes carried on tuser
  typedef enum logic [1:0] {
    CMD_EXEC     = 2'd0,
    CMD_PRELOAD  = 2'd1,
    CMD_READ_REG = 2'd2,
    CMD_READ_MEM = 2'd3
  } cmd_t;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_JAL   = 6'b000011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_HALT  = 6'b111111;

  // R-type function codes
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_SUBU = 6'b100011;
  localparam logic [5:0] FN_AND  = 6'b100100;
  localparam logic [5:0] FN_OR   = 6'b100101;

  // Outcome of one item, carried from execute stage to output stage
  typedef struct packed {
    logic [31:0] data;         // read_data unless taken from memory
    logic        rd_mem;       // read_data comes from data memory
    logic        executed;
    logic        fault;
    logic        halt_seen;
    logic        wr_en;        // register file write pending
    logic        wr_from_mem;  // write value comes from data memory (LW)
    logic [4:0]  wr_addr;
    logic [31:0] wr_data;
  } res_t;

endpackage

### hw/rtl/mss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old word on a same-address write.
module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/mss_exec.sv
// Execute-stage logic: decode, ALU, skip counters, memory request.
// Depends on mss_pkg; purely combinational.
module mss_exec #(
  parameter int MEM_WORDS = mss_pkg::MEM_WORDS_DEFAULT,
  localparam int ADDR_W = $clog2(MEM_WORDS)
) (
  input  mss_pkg::cmd_t     cmd,
  input  logic [31:0]       instr,
  input  logic [4:0]        index,
  input  logic [31:0]       write_data,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [15:0]       bcnt,
  input  logic [24:0]       jcnt,
  output logic [15:0]       bcnt_next,
  output logic [24:0]       jcnt_next,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [31:0]       mem_wdata,
  output mss_pkg::res_t     res
);

  localparam logic [31:0] MemLimit = 32'(MEM_WORDS);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] simm;
  logic [31:0] sum_imm;
  logic [31:0] idx32;
  logic [31:0] alu;
  logic        addr_ok;
  logic        idx_ok;

  // Field decode
  assign op      = instr[31:26];
  assign rt      = instr[20:16];
  assign rd      = instr[15:11];
  assign fn      = instr[5:0];
  assign simm    = {{16{instr[15]}}, instr[15:0]};
  assign sum_imm = a + simm;
  assign idx32   = {27'd0, index};
  assign addr_ok = sum_imm < MemLimit;
  assign idx_ok  = idx32 < MemLimit;

  // R-type ALU; unknown function codes give NOR
  always_comb begin
    case (fn)
      mss_pkg::FN_ADDU: alu = a + b;
      mss_pkg::FN_SUBU: alu = a - b;
      mss_pkg::FN_AND:  alu = a & b;
      mss_pkg::FN_OR:   alu = a | b;
      default:          alu = ~(a | b);
    endcase
  end

  // Command handling and skip counters
  always_comb begin
    bcnt_next = bcnt;
    jcnt_next = jcnt;
    mem_we    = 1'b0;
    mem_addr  = idx32[ADDR_W-1:0];
    mem_wdata = write_data;
    res       = '0;
    case (cmd)
      mss_pkg::CMD_PRELOAD: begin
        if (idx_ok) mem_we = 1'b1;
        else        res.fault = 1'b1;
      end
      mss_pkg::CMD_READ_REG: begin
        res.data = a;
      end
      mss_pkg::CMD_READ_MEM: begin
        if (idx_ok) res.rd_mem = 1'b1;
        else        res.fault = 1'b1;
      end
      mss_pkg::CMD_EXEC: begin
        if (op == mss_pkg::OP_HALT) begin
          // halt leaves all state alone
          res.halt_seen = 1'b1;
          res.executed  = 1'b1;
        end else if (op == mss_pkg::OP_J || op == mss_pkg::OP_JAL) begin
          // jumps ignore the branch count
          if (jcnt != 25'd0) begin
            jcnt_next = jcnt - 25'd1;
          end else begin
            jcnt_next    = instr[25:1];
            res.executed = 1'b1;
          end
        end else if (bcnt != 16'd0) begin
          bcnt_next = bcnt - 16'd1;
        end else if (jcnt != 25'd0) begin
          jcnt_next = jcnt - 25'd1;
        end else begin
          case (op)
            mss_pkg::OP_RTYPE: begin
              res.wr_en    = (rd != 5'd0);
              res.wr_addr  = rd;
              res.wr_data  = alu;
              res.executed = 1'b1;
            end
            mss_pkg::OP_LW, mss_pkg::OP_SW: begin
              mem_addr = sum_imm[ADDR_W-1:0];
              if (!addr_ok) begin
                res.fault = 1'b1;
              end else begin
                res.executed = 1'b1;
                if (op == mss_pkg::OP_LW) begin
                  res.wr_en       = (rt != 5'd0);
                  res.wr_addr     = rt;
                  res.wr_from_mem = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = b;
                end
              end
            end
            mss_pkg::OP_BEQ: begin
              if (a == b) bcnt_next = instr[15:0];
              res.executed = 1'b1;
            end
            default: begin
              // ADDIU and every other opcode
              res.wr_en    = (rt != 5'd0);
              res.wr_addr  = rt;
              res.wr_data  = sum_imm;
              res.executed = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/mips_subset_skip_executor.sv
// MIPS subset skip executor. Takes one command per cycle (execute, preload
// memory word, read register, read memory word) while s_tready is high and
// returns exactly one result per command, in order. Sustained rate is one item
// per clock when the output is not stalled: a register stage holds the register
// file read data, an execute stage resolves the instruction and issues the data
// memory access, and an output stage holds the result and retires the register
// write. Both the register file and the data memory have registered reads;
// results still pending in the output stage are forwarded. After reset the
// data memory is cleared one word per cycle, so s_tready stays low until every
// word has been cleared.
// Depends on mss_pkg, mss_ram, mss_exec and the assertion macro header.
`include "mips_subset_skip_executor_defines.svh"

module mips_subset_skip_executor #(
  parameter int MEM_WORDS = mss_pkg::MEM_WORDS_DEFAULT,
  localparam int ADDR_W = $clog2(MEM_WORDS)
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: instruction[31:0], index[36:32], write_data[68:37], zero[71:69]
  input  logic [71:0] s_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: read_data[31:0], executed[32], fault[33], halt_seen[34], zero[39:35]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready
);

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(MEM_WORDS - 1);

  // Handshake
  logic s_fire;
  logic s1_adv;
  logic s1_fire;
  logic m_fire;

  // Clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;

  // Register stage
  logic               s1_valid;
  mss_pkg::cmd_t      s1_cmd;
  logic [31:0]        s1_instr;
  logic [4:0]         s1_index;
  logic [31:0]        s1_wdata;
  logic [4:0]         s1_ra;
  logic [4:0]         s1_rb;
  logic               s1_ra_vld;
  logic               s1_rb_vld;

  // Output stage
  logic               s2_valid;
  mss_pkg::res_t      s2;
  logic [31:0]        s2_wval;

  // Register file
  logic [31:0] reg_vld;
  logic [4:0]  ra_in;
  logic [4:0]  rb_in;
  logic [31:0] ra_q;
  logic [31:0] rb_q;
  logic        rf_we;
  logic        lw_valid;
  logic [4:0]  lw_addr;
  logic [31:0] lw_data;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // Skip counters
  logic [15:0] bcnt;
  logic [24:0] jcnt;
  logic [15:0] bcnt_next;
  logic [24:0] jcnt_next;

  // Data memory
  logic              ex_mem_we;
  logic [ADDR_W-1:0] ex_mem_addr;
  logic [31:0]       ex_mem_wdata;
  logic              dm_we;
  logic [ADDR_W-1:0] dm_waddr;
  logic [31:0]       dm_wdata;
  logic [31:0]       dm_q;
  mss_pkg::res_t     ex_res;

  // Pipeline flow
  assign m_fire   = m_tvalid && m_tready;
  assign s1_adv   = !s2_valid || m_tready;
  assign s1_fire  = s1_valid && s1_adv;
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s_fire)       s1_valid <= 1'b1;
      else if (s1_fire) s1_valid <= 1'b0;
      if (s1_fire)      s2_valid <= 1'b1;
      else if (m_fire)  s2_valid <= 1'b0;
    end
  end

  // Data memory clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == LastAddr) clearing <= 1'b0;
      else                     clr_cnt  <= clr_cnt + ADDR_W'(1);
    end
  end

  // Register file read addresses, sampled on input transfer
  assign ra_in = (mss_pkg::cmd_t'(s_tuser) == mss_pkg::CMD_EXEC) ? s_tdata[25:21]
                                                                  : s_tdata[36:32];
  assign rb_in = s_tdata[20:16];

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_cmd    <= mss_pkg::cmd_t'(s_tuser);
      s1_instr  <= s_tdata[31:0];
      s1_index  <= s_tdata[36:32];
      s1_wdata  <= s_tdata[68:37];
      s1_ra     <= ra_in;
      s1_rb     <= rb_in;
      s1_ra_vld <= reg_vld[ra_in];
      s1_rb_vld <= reg_vld[rb_in];
    end
  end

  // Register file: two copies give two read ports
  assign s2_wval = s2.wr_from_mem ? dm_q : s2.wr_data;
  assign rf_we   = m_fire && s2.wr_en;

  mss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2.wr_addr),
    .wdata (s2_wval),
    .re    (s_fire),
    .raddr (ra_in),
    .rdata (ra_q)
  );

  mss_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2.wr_addr),
    .wdata (s2_wval),
    .re    (s_fire),
    .raddr (rb_in),
    .rdata (rb_q)
  );

  // Written flags and last write, covering a write on the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld  <= '0;
      lw_valid <= 1'b0;
    end else if (rf_we) begin
      reg_vld[s2.wr_addr] <= 1'b1;
      lw_valid            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      lw_addr <= s2.wr_addr;
      lw_data <= s2_wval;
    end
  end

  // Operand forwarding: pending output-stage write, then last write
  always_comb begin
    if (s2_valid && s2.wr_en && s2.wr_addr == s1_ra) op_a = s2_wval;
    else if (lw_valid && lw_addr == s1_ra)            op_a = lw_data;
    else if (s1_ra_vld)                               op_a = ra_q;
    else                                              op_a = 32'd0;
    if (s2_valid && s2.wr_en && s2.wr_addr == s1_rb) op_b = s2_wval;
    else if (lw_valid && lw_addr == s1_rb)            op_b = lw_data;
    else if (s1_rb_vld)                               op_b = rb_q;
    else                                              op_b = 32'd0;
  end

  // Execute stage
  mss_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
    .cmd        (s1_cmd),
    .instr      (s1_instr),
    .index      (s1_index),
    .write_data (s1_wdata),
    .a          (op_a),
    .b          (op_b),
    .bcnt       (bcnt),
    .jcnt       (jcnt),
    .bcnt_next  (bcnt_next),
    .jcnt_next  (jcnt_next),
    .mem_we     (ex_mem_we),
    .mem_addr   (ex_mem_addr),
    .mem_wdata  (ex_mem_wdata),
    .res        (ex_res)
  );

  // Skip counters advance once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      jcnt <= '0;
    end else if (s1_fire) begin
      bcnt <= bcnt_next;
      jcnt <= jcnt_next;
    end
  end

  // Data memory: clearing pass shares the write port
  assign dm_we    = clearing || (s1_fire && ex_mem_we);
  assign dm_waddr = clearing ? clr_cnt : ex_mem_addr;
  assign dm_wdata = clearing ? 32'd0 : ex_mem_wdata;

  mss_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (s1_fire),
    .raddr (ex_mem_addr),
    .rdata (dm_q)
  );

  // Output stage register
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2 <= ex_res;
    end
  end

  assign m_tvalid = s2_valid;
  assign m_tdata  = {5'd0, s2.halt_seen, s2.fault, s2.executed,
                     (s2.rd_mem ? dm_q : s2.data)};

  // Checks
  `MSS_ASSERT_NOW(a_no_r0_write, s2_valid && s2.wr_en, s2.wr_addr != 5'd0, "write to r0 pending")
  `MSS_ASSERT_NOW(a_exec_xor_fault, m_tvalid, !(m_tdata[32] && m_tdata[33]), "executed with fault")
  `MSS_ASSERT_NOW(a_exec_no_data, m_tvalid && (m_tdata[32] || m_tdata[34]), m_tdata[31:0] == 32'd0, "read_data set for execute")
  `MSS_ASSERT_NEXT(a_halt_keeps_counts, s1_fire && ex_res.halt_seen, $stable(bcnt) && $stable(jcnt), "halt changed skip counts")
  `MSS_ASSERT_NOW(a_no_accept_clearing, clearing, !s_fire && !s1_valid, "item taken during clearing")

endmodule

### tb/testbench.sv
// Self-checking testbench for mips_subset_skip_executor: stream transfers in,
// results predicted by a scoreboard class and compared in arrival order.
// Depends on mss_pkg and the executor RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int MEM_WORDS = mss_pkg::MEM_WORDS_DEFAULT;
  localparam int LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1500;

  // Codes used by the stimulus beyond those in the package
  localparam logic [5:0] OP_ADDIU = 6'b001001;
  localparam logic [5:0] FN_NOR   = 6'b100111;

  // One result transfer, fields as carried on m_tdata
  typedef struct packed {
    logic [31:0] read_data;
    logic        executed;
    logic        fault;
    logic        halt_seen;
  } outcome_t;

  // Architectural model plus the queue of outcomes still owed by the block
  class exec_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] mem [MEM_WORDS];
    logic [15:0] br_skip;
    logic [24:0] jmp_skip;
    outcome_t    owed_q [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      br_skip = '0;
      jmp_skip = '0;
      errors = 0;
    endfunction

    function void put_reg(logic [4:0] n, logic [31:0] v);
      if (n != 5'd0) regs[n] = v;
    endfunction

    // Apply one accepted command to the model and queue its outcome
    function void note_input(mss_pkg::cmd_t cmd, logic [31:0] ins, logic [4:0] idx,
                             logic [31:0] wdata);
      outcome_t    r;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [31:0] simm;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] addr;
      logic [31:0] alu;
      r = '0;
      op = ins[31:26];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      fn = ins[5:0];
      simm = {{16{ins[15]}}, ins[15:0]};
      a = regs[rs];
      b = regs[rt];
      case (cmd)
        mss_pkg::CMD_PRELOAD: begin
          if (idx < MEM_WORDS) mem[idx] = wdata;
          else r.fault = 1'b1;
        end
        mss_pkg::CMD_READ_REG: r.read_data = regs[idx];
        mss_pkg::CMD_READ_MEM: begin
          if (idx < MEM_WORDS) r.read_data = mem[idx];
          else r.fault = 1'b1;
        end
        default: begin
          if (op == mss_pkg::OP_HALT) begin
            // halt leaves both skip counts alone
            r.halt_seen = 1'b1;
            r.executed = 1'b1;
          end else if (op == mss_pkg::OP_J || op == mss_pkg::OP_JAL) begin
            // jumps ignore the branch count
            if (jmp_skip != 0) begin
              jmp_skip--;
            end else begin
              jmp_skip = ins[25:1];
              r.executed = 1'b1;
            end
          end else if (br_skip != 0) begin
            br_skip--;
          end else if (jmp_skip != 0) begin
            jmp_skip--;
          end else begin
            case (op)
              mss_pkg::OP_RTYPE: begin
                case (fn)
                  mss_pkg::FN_ADDU: alu = a + b;
                  mss_pkg::FN_SUBU: alu = a - b;
                  mss_pkg::FN_AND:  alu = a & b;
                  mss_pkg::FN_OR:   alu = a | b;
                  default:          alu = ~(a | b);
                endcase
                put_reg(rd, alu);
                r.executed = 1'b1;
              end
              mss_pkg::OP_LW, mss_pkg::OP_SW: begin
                addr = a + simm;
                if (addr >= MEM_WORDS) begin
                  r.fault = 1'b1;
                end else begin
                  if (op == mss_pkg::OP_LW) put_reg(rt, mem[addr]);
                  else mem[addr] = b;
                  r.executed = 1'b1;
                end
              end
              mss_pkg::OP_BEQ: begin
                if (a == b) br_skip = ins[15:0];
                r.executed = 1'b1;
              end
              default: begin
                put_reg(rt, a + simm);
                r.executed = 1'b1;
              end
            endcase
          end
        end
      endcase
      owed_q.insert(owed_q.size(), r);
    endfunction

    // Compare one result transfer with the oldest outcome owed
    function void check_result(logic [39:0] d);
      outcome_t got;
      outcome_t want;
      got.read_data = d[31:0];
      got.executed = d[32];
      got.fault = d[33];
      got.halt_seen = d[34];
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none owed: data=%h exe=%b flt=%b halt=%b",
                   $time, got.read_data, got.executed, got.fault, got.halt_seen);
      end else begin
        want = owed_q.pop_front();
        if (got.read_data !== want.read_data || got.executed !== want.executed ||
            got.fault !== want.fault || got.halt_seen !== want.halt_seen) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: mismatch exp data=%h exe=%b flt=%b halt=%b, ",
                      "got data=%h exe=%b flt=%b halt=%b"},
                     $time, want.read_data, want.executed, want.fault, want.halt_seen,
                     got.read_data, got.executed, got.fault, got.halt_seen);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  exec_scoreboard book = new();
  int  accepted = 0;
  bit  tx_busy = 1'b1;
  bit  rx_busy = 1'b1;
  bit  hold_rx = 1'b0;
  int  rx_gap = 0;
  int  rx_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mips_subset_skip_executor DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // Instruction encoders
  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [5:0] fn);
    logic [4:0] shamt;
    shamt = 5'($urandom);
    return {mss_pkg::OP_RTYPE, rs, rt, rd, shamt, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  // Offer one transfer after a random gap and wait for it to be taken
  task automatic send_item(mss_pkg::cmd_t cmd, logic [31:0] ins, logic [4:0] idx,
                           logic [31:0] wd);
    int gap;
    gap = tx_busy ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {3'b000, wd, idx, ins};
    s_tuser <= cmd;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_input(cmd, ins, idx, wd);
    accepted++;
  endtask

  task automatic exec(logic [31:0] ins);
    send_item(mss_pkg::CMD_EXEC, ins, 5'($urandom), $urandom);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2, 3: return 32'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  // Random commands: mostly well-formed instructions with random content, some noise
  task automatic send_random();
    int          pick;
    int          kind;
    int          tgt;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [31:0] ins;
    pick = $urandom_range(0, 99);
    rs = 5'($urandom);
    rt = 5'($urandom);
    rd = 5'($urandom);
    ins = $urandom;
    if (pick < 10) begin
      send_item(mss_pkg::CMD_PRELOAD, ins, rs, pick_word());
    end else if (pick < 18) begin
      send_item(mss_pkg::CMD_READ_REG, ins, rs, $urandom);
    end else if (pick < 26) begin
      send_item(mss_pkg::CMD_READ_MEM, ins, rs, $urandom);
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        case ($urandom_range(0, 5))
          0: fn = mss_pkg::FN_ADDU;
          1: fn = mss_pkg::FN_SUBU;
          2: fn = mss_pkg::FN_AND;
          3: fn = mss_pkg::FN_OR;
          4: fn = FN_NOR;
          default: fn = 6'($urandom);
        endcase
        ins = r_word(rs, rt, rd, fn);
      end else if (kind < 45) begin
        // any opcode without a meaning of its own behaves as add-immediate
        do op = 6'($urandom);
        while (op == mss_pkg::OP_RTYPE || op == mss_pkg::OP_J || op == mss_pkg::OP_JAL ||
               op == mss_pkg::OP_BEQ || op == mss_pkg::OP_LW || op == mss_pkg::OP_SW ||
               op == mss_pkg::OP_HALT);
        imm = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        ins = i_word(op, rs, rt, imm);
      end else if (kind < 65) begin
        op = ($urandom_range(0, 1) != 0) ? mss_pkg::OP_LW : mss_pkg::OP_SW;
        if ($urandom_range(0, 1) != 0) rs = 5'd0;
        if ($urandom_range(0, 3) != 0) begin
          tgt = $urandom_range(0, MEM_WORDS - 1);
          imm = 16'(32'(tgt) - book.regs[rs]);
        end else begin
          imm = 16'($urandom);
        end
        ins = i_word(op, rs, rt, imm);
      end else if (kind < 78) begin
        if ($urandom_range(0, 1) != 0) rt = rs;
        imm = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) :
                                           16'($urandom_range(0, 12));
        ins = i_word(mss_pkg::OP_BEQ, rs, rt, imm);
      end else if (kind < 86) begin
        op = ($urandom_range(0, 1) != 0) ? mss_pkg::OP_J : mss_pkg::OP_JAL;
        ins = j_word(op, 26'($urandom_range(0, 11)));
      end else if (kind < 90) begin
        ins = j_word(mss_pkg::OP_HALT, 26'($urandom));
      end else begin
        // raw noise, with skip lengths kept short
        if (ins[31:26] == mss_pkg::OP_J || ins[31:26] == mss_pkg::OP_JAL) ins[25:4] = '0;
        if (ins[31:26] == mss_pkg::OP_BEQ) ins[15:4] = '0;
      end
      exec(ins);
    end
  endtask

  // Receiver: random stall per result, plus long holds from rx_hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        book.check_result(m_tdata);
        rx_count++;
        if (rx_count % 64 == 0) rx_busy = ($urandom_range(0, 2) != 0);
        rx_gap = rx_busy ? $urandom_range(0, 13) : 0;
      end else if (rx_gap != 0) begin
        rx_gap--;
      end
      m_tready <= (rx_gap == 0) && !hold_rx;
    end
  end

  // Long receiver holds so the pipeline fills and back-pressures the input
  initial begin : rx_hold
    int mark;
    for (mark = 200; mark <= 900; mark += 700) begin
      wait (accepted >= mark);
      @(posedge clk);
      hold_rx <= 1'b1;
      repeat (300) @(posedge clk);
      hold_rx <= 1'b0;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads, preloads, every operation and the skip behaviour
    send_item(mss_pkg::CMD_READ_REG, '0, 5'd0, '0);
    send_item(mss_pkg::CMD_PRELOAD, '1, 5'd0, 32'hFFFF_FFFF);
    send_item(mss_pkg::CMD_PRELOAD, '0, 5'd31, 32'd5);
    send_item(mss_pkg::CMD_READ_MEM, '0, 5'd31, '0);
    exec(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    exec(i_word(OP_ADDIU, 5'd0, 5'd2, 16'h8000));   // sign-extended immediate
    exec(i_word(OP_ADDIU, 5'd0, 5'd0, 16'd5));      // write to register zero dropped
    exec(r_word(5'd1, 5'd2, 5'd3, mss_pkg::FN_ADDU));
    exec(r_word(5'd1, 5'd2, 5'd4, mss_pkg::FN_SUBU));
    exec(r_word(5'd1, 5'd2, 5'd5, mss_pkg::FN_AND));
    exec(r_word(5'd1, 5'd2, 5'd6, mss_pkg::FN_OR));
    exec(r_word(5'd1, 5'd2, 5'd7, 6'b000000));      // unknown funct acts as NOR
    exec(i_word(mss_pkg::OP_LW, 5'd0, 5'd8, 16'd31));
    exec(i_word(mss_pkg::OP_LW, 5'd0, 5'd9, 16'd32));   // just past the end of memory
    exec(i_word(mss_pkg::OP_SW, 5'd8, 5'd2, 16'hFFFC)); // negative offset, word 1
    exec(i_word(mss_pkg::OP_SW, 5'd0, 5'd2, 16'hFFFF)); // wraps to a huge address
    send_item(mss_pkg::CMD_READ_MEM, '0, 5'd1, '0);
    exec(i_word(mss_pkg::OP_BEQ, 5'd0, 5'd9, 16'd0));   // taken, zero offset skips nothing
    exec(i_word(mss_pkg::OP_BEQ, 5'd1, 5'd2, 16'd3));   // not taken
    exec(i_word(mss_pkg::OP_BEQ, 5'd0, 5'd0, 16'd2));
    exec(i_word(OP_ADDIU, 5'd0, 5'd11, 16'd1));         // skipped
    exec(j_word(mss_pkg::OP_HALT, '1));                 // halt does not touch the counts
    exec(j_word(mss_pkg::OP_J, 26'd6));                 // jump ignores branch count
    exec(r_word(5'd1, 5'd1, 5'd12, mss_pkg::FN_ADDU));  // skipped, branch count empties
    exec(j_word(mss_pkg::OP_JAL, 26'h3FF_FFFE));        // only decrements jump count
    exec(i_word(OP_ADDIU, 5'd0, 5'd13, 16'd1));         // skipped on jump count
    send_item(mss_pkg::CMD_READ_REG, '0, 5'd11, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) tx_busy = ($urandom_range(0, 2) != 0);
      send_random();
    end

    // Drain both counts, then load each to its largest value
    while (book.br_skip != 0) exec(i_word(OP_ADDIU, 5'd0, 5'd0, 16'd0));
    while (book.jmp_skip != 0) exec(j_word(mss_pkg::OP_J, 26'd0));
    exec(i_word(mss_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    exec(j_word(mss_pkg::OP_J, 26'h3FF_FFFF));
    exec(i_word(OP_ADDIU, 5'd0, 5'd14, 16'd7));
    exec(j_word(mss_pkg::OP_JAL, 26'd2));
    send_item(mss_pkg::CMD_READ_REG, '0, 5'd31, '0);
    send_item(mss_pkg::CMD_READ_MEM, '0, 5'd0, '0);
    s_tvalid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mss_pkg.sv
hw/rtl/mss_ram.sv
hw/rtl/mss_exec.sv
hw/rtl/mips_subset_skip_executor.sv
tb/testbench.sv
